// ===== hw/rtl/tbfh_pkg.sv =====
// Shared constants, register codes and types of the flow histogram core.
package tbfh_pkg;

    localparam int NUM_BINS     = 64;
    localparam int COUNT_BITS   = 16;
    localparam int BIN_BITS     = $clog2(NUM_BINS);
    localparam int NCNT_BITS    = $clog2(NUM_BINS + 1);
    localparam int CNT_OUT_BITS = 16;
    localparam int SEC_BITS     = 32;
    localparam int STN_BITS     = 8;
    localparam int MIN_BITS     = 11;
    localparam int SECS_PER_MIN = 60;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    // Divider resolves two quotient bits per step
    localparam int DIV_STEPS = (BIN_BITS + 1) / 2;
    localparam int QUO_BITS  = 2 * DIV_STEPS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_STATION  = 2'd0,
        CFG_START    = 2'd1,
        CFG_END      = 2'd2,
        CFG_INTERVAL = 2'd3
    } cfg_idx_t;

    // Work handed from the front end to the bin engine
    typedef struct packed {
        logic                 fin;
        logic [BIN_BITS-1:0]  bin;
        logic                 entering;
        logic [NCNT_BITS-1:0] nbins;
    } job_t;

    typedef struct packed {
        logic                done;
        logic                ovf;
        logic [BIN_BITS-1:0] quo;
    } div_res_t;

endpackage

// ===== hw/rtl/tbfh_if.sv =====
// Handshake channels of the flow histogram core: records, bin results, register writes.
interface tbfh_req_if;
    import tbfh_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [SEC_BITS-1:0] record_seconds;
    logic [STN_BITS-1:0] record_station;
    logic                entering;

    modport source (output valid, output req_type, output record_seconds,
                    output record_station, output entering, input ready);
    modport sink   (input valid, input req_type, input record_seconds,
                    input record_station, input entering, output ready);
endinterface

interface tbfh_bin_if;
    import tbfh_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [BIN_BITS-1:0]     bin_number;
    logic [CNT_OUT_BITS-1:0] inflow_count;
    logic [CNT_OUT_BITS-1:0] outflow_count;
    logic [CNT_OUT_BITS-1:0] peak_count;
    logic                    final_bin;

    modport source (output valid, output bin_number, output inflow_count,
                    output outflow_count, output peak_count, output final_bin,
                    input ready);
    modport sink   (input valid, input bin_number, input inflow_count,
                    input outflow_count, input peak_count, input final_bin,
                    output ready);
endinterface

interface tbfh_cfg_if;
    import tbfh_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/time_binned_flow_histogram_core.sv =====
// Time-binned flow histogram core: top level joining front end, job queue and bin engine.
// A record for the selected station at or after the start time is binned by
// (seconds - start) / (interval * 60) and bumps that bin's saturating in or out counter;
// a finish item reads out every bin in use, in order, with the peak, then clears all.
// A record that passes the station, start and window checks holds the front end while the
// bin index divider works (load, range check, three two-bit steps, result), then for the
// hand-off, unless its bin lies past the window and it is dropped after the divide; any
// other record is dropped when taken and a finish goes straight to the hand-off. A hand-off
// also waits while the job queue is full. Each register write makes the front end
// recompute the bin count before it takes another item. The bin engine updates a counter
// by a RAM read, then a write, and reads out each bin by read, load and output states plus
// any wait on the result channel; a 4-entry job queue lets the two sides stall on their own.
module time_binned_flow_histogram_core (
    input  logic       clk,
    input  logic       rst_n,
    tbfh_req_if.sink   req,
    tbfh_bin_if.source res,
    tbfh_cfg_if.sink   cfg
);
    import tbfh_pkg::*;

    logic push_valid;
    logic push_ready;
    job_t push_item;
    logic pop_valid;
    logic pop_ready;
    job_t pop_item;

    tbfh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    tbfh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    tbfh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .res       (res)
    );

endmodule

// ===== hw/rtl/tbfh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tbfh_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/tbfh_div.sv =====
// Multi-cycle bin index divider: offset seconds over interval, flagging overflow at the bin count.
module tbfh_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tbfh_pkg::SEC_BITS-1:0] dividend,
    input  logic [tbfh_pkg::MIN_BITS-1:0] minutes,
    output tbfh_pkg::div_res_t            res
);
    import tbfh_pkg::*;

    localparam int STEP_BITS = $clog2(DIV_STEPS) + 1;

    typedef enum logic [1:0] {
        D_IDLE,
        D_OVF,
        D_STEP
    } dstate_t;

    dstate_t              state_reg;
    logic [SEC_BITS-1:0]  rem_reg;
    logic [SEC_BITS-1:0]  dsr_reg;
    logic [SEC_BITS-1:0]  dsh_reg;
    logic [QUO_BITS-1:0]  quo_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 ovf_reg;
    logic                 done_reg;

    logic [SEC_BITS-1:0] secs;
    logic [SEC_BITS-1:0] t_hi;
    logic [SEC_BITS-1:0] r1;
    logic [SEC_BITS-1:0] r2;
    logic                b_hi;
    logic                b_lo;

    // zero minutes counts as one
    assign secs = ((minutes == '0) ? SEC_BITS'(1) : SEC_BITS'(minutes))
                  * SEC_BITS'(SECS_PER_MIN);

    // two restoring steps per cycle, shifted divisor walks down by two
    always_comb
    begin
        t_hi = dsh_reg << 1;
        b_hi = (rem_reg >= t_hi);
        r1   = b_hi ? (rem_reg - t_hi) : rem_reg;
        b_lo = (r1 >= dsh_reg);
        r2   = b_lo ? (r1 - dsh_reg) : r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= dividend;
                        dsr_reg   <= secs;
                        state_reg <= D_OVF;
                    end
                end
                D_OVF:
                begin
                    ovf_reg   <= (rem_reg >= dsr_reg * SEC_BITS'(NUM_BINS));
                    dsh_reg   <= dsr_reg << (QUO_BITS - 2);
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= D_STEP;
                end
                D_STEP:
                begin
                    rem_reg  <= r2;
                    dsh_reg  <= dsh_reg >> 2;
                    quo_reg  <= (quo_reg << 2) | QUO_BITS'({b_hi, b_lo});
                    step_reg <= step_reg + STEP_BITS'(1);
                    if (step_reg == STEP_BITS'(DIV_STEPS - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = quo_reg[BIN_BITS-1:0];

endmodule

// ===== hw/rtl/tbfh_front.sv =====
// Front end: register file, record filtering and bin index computation.
module tbfh_front (
    input  logic                clk,
    input  logic                rst_n,
    tbfh_req_if.sink            req,
    tbfh_cfg_if.sink            cfg,
    output logic                push_valid,
    input  logic                push_ready,
    output tbfh_pkg::job_t      push_item
);
    import tbfh_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_NCALC,
        F_DIV,
        F_PUSH
    } fstate_t;

    fstate_t              state_reg;
    logic [STN_BITS-1:0]  station_reg;
    logic [SEC_BITS-1:0]  start_reg;
    logic [SEC_BITS-1:0]  end_reg;
    logic [MIN_BITS-1:0]  minutes_reg;
    logic [NCNT_BITS-1:0] nbins_reg;
    logic                 n_dirty_reg;
    job_t                 job_reg;

    logic                cfg_wr;
    logic                req_acc;
    logic                rec_hit;
    logic                window_ok;
    logic                div_start;
    logic [SEC_BITS-1:0] div_dividend;
    div_res_t            div_res;

    assign cfg.ready  = 1'b1;
    assign cfg_wr     = cfg.valid;
    assign req.ready  = (state_reg == F_IDLE) && !n_dirty_reg;
    assign req_acc    = req.valid && req.ready;
    assign window_ok  = (end_reg > start_reg);
    assign rec_hit    = (req.req_type == REQ_RECORD)
                        && (req.record_station == station_reg)
                        && (req.record_seconds >= start_reg)
                        && (nbins_reg != '0);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = req.record_seconds - start_reg;
        if (state_reg == F_IDLE)
        begin
            if (n_dirty_reg)
            begin
                div_start    = window_ok;
                div_dividend = end_reg - start_reg;
            end
            else
            begin
                div_start = req_acc && rec_hit;
            end
        end
    end

    tbfh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .minutes  (minutes_reg),
        .res      (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            station_reg <= '0;
            start_reg   <= '0;
            end_reg     <= SEC_BITS'(3600);
            minutes_reg <= MIN_BITS'(60);
            nbins_reg   <= '0;
            n_dirty_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (n_dirty_reg)
                    begin
                        n_dirty_reg <= 1'b0;
                        if (window_ok)
                        begin
                            state_reg <= F_NCALC;
                        end
                        else
                        begin
                            nbins_reg <= '0;
                        end
                    end
                    else if (req_acc)
                    begin
                        job_reg.entering <= req.entering;
                        job_reg.nbins    <= nbins_reg;
                        job_reg.bin      <= '0;
                        if (req.req_type == REQ_FINISH)
                        begin
                            job_reg.fin <= 1'b1;
                            state_reg   <= F_PUSH;
                        end
                        else if (rec_hit)
                        begin
                            job_reg.fin <= 1'b0;
                            state_reg   <= F_DIV;
                        end
                    end
                end
                F_NCALC:
                begin
                    if (div_res.done)
                    begin
                        nbins_reg <= div_res.ovf ? NCNT_BITS'(NUM_BINS)
                                   : NCNT_BITS'(div_res.quo) + NCNT_BITS'(1);
                        state_reg <= F_IDLE;
                    end
                end
                F_DIV:
                begin
                    if (div_res.done)
                    begin
                        job_reg.bin <= div_res.quo;
                        if (!div_res.ovf && (NCNT_BITS'(div_res.quo) < nbins_reg))
                        begin
                            state_reg <= F_PUSH;
                        end
                        else
                        begin
                            state_reg <= F_IDLE;
                        end
                    end
                end
                F_PUSH:
                begin
                    if (push_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase

            // a write always forces a fresh bin count
            if (cfg_wr)
            begin
                n_dirty_reg <= 1'b1;
                case (cfg_idx_t'(cfg.index))
                    CFG_STATION:  station_reg <= cfg.data[STN_BITS-1:0];
                    CFG_START:    start_reg   <= cfg.data[SEC_BITS-1:0];
                    CFG_END:      end_reg     <= cfg.data[SEC_BITS-1:0];
                    CFG_INTERVAL: minutes_reg <= cfg.data[MIN_BITS-1:0];
                    default:      ;
                endcase
            end
        end
    end

    assign push_valid = (state_reg == F_PUSH);
    assign push_item  = job_reg;

endmodule

// ===== hw/rtl/tbfh_queue.sv =====
// Short job queue between the front end and the bin engine.
module tbfh_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tbfh_pkg::job_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tbfh_pkg::job_t pop_item
);
    import tbfh_pkg::*;

    job_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wptr_reg;
    logic [QPTR_BITS-1:0] rptr_reg;
    logic [QPTR_BITS:0]   fill_reg;

    logic do_push;
    logic do_pop;

    assign push_ready = (fill_reg != (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : wptr_reg + QPTR_BITS'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                          : rptr_reg + QPTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + (QPTR_BITS + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - (QPTR_BITS + 1)'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/tbfh_back.sv =====
// Bin engine: counter update in RAM, peak tracking, readout and clear on finish.
module tbfh_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  tbfh_pkg::job_t pop_item,
    tbfh_bin_if.source     res
);
    import tbfh_pkg::*;

    localparam int WORD_BITS = 2 * COUNT_BITS;

    typedef enum logic [2:0] {
        B_IDLE,
        B_UPD,
        B_FRD,
        B_FLOAD,
        B_FOUT
    } bstate_t;

    bstate_t                 state_reg;
    job_t                    job_reg;
    logic [NUM_BINS-1:0]     filled_reg;
    logic [COUNT_BITS-1:0]   peak_reg;
    logic [NCNT_BITS-1:0]    k_reg;
    logic [BIN_BITS-1:0]     bin_out_reg;
    logic [CNT_OUT_BITS-1:0] in_out_reg;
    logic [CNT_OUT_BITS-1:0] out_out_reg;
    logic [CNT_OUT_BITS-1:0] peak_out_reg;
    logic                    final_out_reg;

    logic                  ram_we;
    logic                  ram_re;
    logic [BIN_BITS-1:0]   ram_raddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_BITS-1:0]  ram_rdata;
    logic [WORD_BITS-1:0]  cur_word;
    logic [WORD_BITS-1:0]  rd_word;
    logic [COUNT_BITS-1:0] cnt_old;
    logic [COUNT_BITS-1:0] cnt_new;

    assign pop_ready = (state_reg == B_IDLE);
    assign ram_we    = (state_reg == B_UPD);
    assign ram_re    = (state_reg == B_FRD)
                       || ((state_reg == B_IDLE) && pop_valid && !pop_item.fin);
    assign ram_raddr = (state_reg == B_FRD) ? k_reg[BIN_BITS-1:0] : pop_item.bin;

    // entries not written since the last clear read as zero
    always_comb
    begin
        cur_word = filled_reg[job_reg.bin] ? ram_rdata : '0;
        rd_word  = filled_reg[k_reg[BIN_BITS-1:0]] ? ram_rdata : '0;
        cnt_old  = job_reg.entering ? cur_word[WORD_BITS-1:COUNT_BITS]
                                    : cur_word[COUNT_BITS-1:0];
        cnt_new  = (cnt_old == {COUNT_BITS{1'b1}}) ? cnt_old
                                                   : cnt_old + COUNT_BITS'(1);
        ram_wdata = job_reg.entering ? {cnt_new, cur_word[COUNT_BITS-1:0]}
                                     : {cur_word[WORD_BITS-1:COUNT_BITS], cnt_new};
    end

    tbfh_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (job_reg.bin),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            filled_reg <= '0;
            peak_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                    begin
                        job_reg <= pop_item;
                        k_reg   <= '0;
                        if (!pop_item.fin)
                        begin
                            state_reg <= B_UPD;
                        end
                        else if (pop_item.nbins == '0)
                        begin
                            filled_reg <= '0;
                            peak_reg   <= '0;
                        end
                        else
                        begin
                            state_reg <= B_FRD;
                        end
                    end
                end
                B_UPD:
                begin
                    filled_reg[job_reg.bin] <= 1'b1;
                    if (cnt_new > peak_reg)
                    begin
                        peak_reg <= cnt_new;
                    end
                    state_reg <= B_IDLE;
                end
                B_FRD:
                begin
                    state_reg <= B_FLOAD;
                end
                B_FLOAD:
                begin
                    bin_out_reg   <= k_reg[BIN_BITS-1:0];
                    in_out_reg    <= CNT_OUT_BITS'(rd_word[WORD_BITS-1:COUNT_BITS]);
                    out_out_reg   <= CNT_OUT_BITS'(rd_word[COUNT_BITS-1:0]);
                    peak_out_reg  <= CNT_OUT_BITS'(peak_reg);
                    final_out_reg <= ((k_reg + NCNT_BITS'(1)) == job_reg.nbins);
                    state_reg     <= B_FOUT;
                end
                B_FOUT:
                begin
                    if (res.ready)
                    begin
                        if (final_out_reg)
                        begin
                            filled_reg <= '0;
                            peak_reg   <= '0;
                            state_reg  <= B_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + NCNT_BITS'(1);
                            state_reg <= B_FRD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign res.valid         = (state_reg == B_FOUT);
    assign res.bin_number    = bin_out_reg;
    assign res.inflow_count  = in_out_reg;
    assign res.outflow_count = out_out_reg;
    assign res.peak_count    = peak_out_reg;
    assign res.final_bin     = final_out_reg;

endmodule
